// ===== rtl/textured_wall_column_sampler_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the textured wall column sampler
// Concurrent property checks, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_WALL_COLUMN_SAMPLER_CORE_ASSERT_SVH
`define TEXTURED_WALL_COLUMN_SAMPLER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication.
`define TWS_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Next-cycle implication.
`define TWS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define TWS_ASSERT_IMP(lbl, pre, post, msg)
`define TWS_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

// ===== rtl/tws_pkg.sv =====
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants, codes and types of the textured wall column sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package tws_pkg;

  localparam int unsigned TEX_SIZE_DEF = 64;

  localparam int unsigned SCREEN_H_W  = 13;
  localparam logic [SCREEN_H_W-1:0] SCREEN_H_RST = 13'd480;

  localparam int unsigned COLOR_W     = 24;
  localparam int unsigned FACE_W      = 2;
  localparam int unsigned FACE_ADDR_W = 12;
  localparam int unsigned MEM_ADDR_W  = FACE_W + FACE_ADDR_W;
  localparam int unsigned MEM_DEPTH   = 1 << MEM_ADDR_W;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned ROW_W       = 12;
  localparam int unsigned END_W       = 13;
  localparam int unsigned COL_W       = 12;

  // Each channel halved: the top bit of every byte is cleared.
  localparam logic [COLOR_W-1:0] HALF_MASK = 24'h7F7F7F;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_START = 2'd1,
    ACT_ROW   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    FACE_NORTH = 2'd0,
    FACE_SOUTH = 2'd1,
    FACE_EAST  = 2'd2,
    FACE_WEST  = 2'd3
  } face_e;

  typedef struct packed {
    logic                  wr_en;
    logic                  rd_en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [COLOR_W-1:0]    wdata;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/tws_texel_ram.sv =====
// ----------------------------------------------------------------------------
// tws_texel_ram
// Texel store for all four faces: one port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_texel_ram (
  input  logic                                clk_i,
  input  tws_pkg::mem_req_t                   req_i,
  output logic [tws_pkg::COLOR_W-1:0]         rdata_o
);
  import tws_pkg::*;

  logic [COLOR_W-1:0] mem_q [MEM_DEPTH];
  logic [COLOR_W-1:0] rdata_q;

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/tws_step_div.sv =====
// ----------------------------------------------------------------------------
// tws_step_div
// Restoring divider, one quotient bit a cycle, for (TEX_SIZE << 16) / height.
// ----------------------------------------------------------------------------
`default_nettype none

module tws_step_div #(
  parameter int unsigned TEX_SIZE = tws_pkg::TEX_SIZE_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [tws_pkg::HEIGHT_W-1:0]  divisor_i,
  output logic                          done_o,
  output logic [31:0]                   quot_o
);
  import tws_pkg::*;

  localparam int unsigned TEX_W = $clog2(TEX_SIZE);
  localparam int unsigned DVD_W = TEX_W + 17;
  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam logic [DVD_W-1:0] DIVIDEND = DVD_W'(TEX_SIZE) << 16;

  logic [CNT_W-1:0]    cnt_q;
  logic                done_q;
  logic [HEIGHT_W-1:0] rem_q;
  logic [HEIGHT_W-1:0] div_q;
  logic [DVD_W-1:0]    dvd_q;
  logic [DVD_W-1:0]    quot_q;

  logic [HEIGHT_W:0]   rem_sh;
  logic [HEIGHT_W+1:0] diff;
  logic                q_bit;
  logic [HEIGHT_W-1:0] rem_d;

  always_comb begin
    rem_sh = {rem_q, dvd_q[DVD_W-1]};
    diff   = {1'b0, rem_sh} - {2'b00, div_q};
    q_bit  = ~diff[HEIGHT_W+1];
    rem_d  = q_bit ? diff[HEIGHT_W-1:0] : rem_sh[HEIGHT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (cnt_q == CNT_W'(1));
      if (start_i) begin
        cnt_q <= CNT_W'(DVD_W);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      div_q  <= divisor_i;
      dvd_q  <= DIVIDEND;
      quot_q <= '0;
    end else if (cnt_q != '0) begin
      rem_q  <= rem_d;
      dvd_q  <= dvd_q << 1;
      quot_q <= {quot_q[DVD_W-2:0], q_bit};
    end
  end

  assign done_o = done_q;
  assign quot_o = 32'(quot_q);

endmodule

`default_nettype wire

// ===== rtl/textured_wall_column_sampler_core.sv =====
// ----------------------------------------------------------------------------
// textured_wall_column_sampler_core
// Raycaster wall column texturing: texel loading, column setup, row pixels.
// ----------------------------------------------------------------------------
// A load item writes one texel into the single-port texel store and leaves
// the block idle. A row item reads the texel from the store, whose read data
// is registered, and in the ST_READ state places the shaded pixel in the
// output register; the next item is accepted while that pixel still waits to
// be taken. A start item passes through the ST_DIV and ST_MUL states: the
// vertical step comes from a restoring divider that yields one quotient bit a
// cycle, and the start position then needs one 32-bit multiplication. While a
// row pixel cannot move into a full output register, or a start is being
// worked out, no item is accepted. Row items that find the column exhausted,
// and items with an unused action code, are taken without leaving the idle
// state and give no pixel. The texel store has no reset: a row that reads a
// texel never loaded gives a colour that is not defined. The screen height
// register may be written at any time the block is idle; its write channel is
// always ready.
// ----------------------------------------------------------------------------
`default_nettype none

module textured_wall_column_sampler_core #(
  parameter int unsigned TEX_SIZE = tws_pkg::TEX_SIZE_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tws_pkg::SCREEN_H_W-1:0]    cfg_data_i,      // screen_height

  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // face, texel_addr, texel_color, hit_side, ray_x_negative, ray_y_positive,
  // wall_frac, slice_height, first_row, end_row, screen_column, zero fill
  input  logic [111:0]                      s_axis_tdata,
  input  logic [1:0]                        s_axis_tuser,    // action

  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,    // pixel_row, pixel_column,
                                                              // pixel_color
  output logic                              m_axis_tuser,    // write_enable
  output logic                              m_axis_tlast     // last
);
  import tws_pkg::*;

  `include "textured_wall_column_sampler_core_assert.svh"

  localparam int unsigned TEX_W = $clog2(TEX_SIZE);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_MUL  = 2'd3;

  // Input fields.
  action_e                in_action;
  logic [FACE_W-1:0]      in_face;
  logic [FACE_ADDR_W-1:0] in_addr;
  logic [COLOR_W-1:0]     in_color;
  logic                   in_side;
  logic                   in_xneg;
  logic                   in_ypos;
  logic [15:0]            in_frac;
  logic [HEIGHT_W-1:0]    in_height;
  logic [ROW_W-1:0]       in_first;
  logic [END_W-1:0]       in_end;
  logic [COL_W-1:0]       in_column;

  assign in_action = action_e'(s_axis_tuser);
  assign in_face   = s_axis_tdata[1:0];
  assign in_addr   = s_axis_tdata[13:2];
  assign in_color  = s_axis_tdata[37:14];
  assign in_side   = s_axis_tdata[38];
  assign in_xneg   = s_axis_tdata[39];
  assign in_ypos   = s_axis_tdata[40];
  assign in_frac   = s_axis_tdata[56:41];
  assign in_height = s_axis_tdata[72:57];
  assign in_first  = s_axis_tdata[84:73];
  assign in_end    = s_axis_tdata[97:85];
  assign in_column = s_axis_tdata[109:98];

  // Control and column state.
  logic [1:0]            state_q;
  logic [SCREEN_H_W-1:0] screen_h_q;
  logic [FACE_W-1:0]     face_q;
  logic [TEX_W-1:0]      tcol_q;
  logic [31:0]           acc_q;
  logic [31:0]           step_q;
  logic [END_W-1:0]      row_q;
  logic [END_W-1:0]      limit_q;
  logic [COL_W-1:0]      col_latch_q;
  logic [31:0]           base_q;

  // Row in flight and output register.
  logic [ROW_W-1:0]      pend_row_q;
  logic                  pend_last_q;
  logic                  out_valid_q;
  logic [ROW_W-1:0]      out_row_q;
  logic [COL_W-1:0]      out_col_q;
  logic [COLOR_W-1:0]    out_color_q;
  logic                  out_we_q;
  logic                  out_last_q;

  logic                  s_accept;
  logic                  m_accept;
  logic                  is_load;
  logic                  is_start;
  logic                  row_go;
  logic                  out_load;

  logic [FACE_W-1:0]     start_face;
  logic                  start_mirror;
  logic [TEX_W-1:0]      start_tcol;
  logic [HEIGHT_W-1:0]   height_nz;
  logic [31:0]           start_base;
  logic [TEX_W-1:0]      tex_row;
  logic [2*TEX_W-1:0]    tex_xy;
  logic [31:0]           start_pos;
  logic [COLOR_W-1:0]    texel;
  logic [COLOR_W-1:0]    shaded;

  logic                  div_done;
  logic [31:0]           div_quot;
  mem_req_t              mem_req;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign s_accept      = s_axis_tvalid & s_axis_tready;
  assign m_accept      = m_axis_tvalid & m_axis_tready;

  assign is_load  = s_accept && (in_action == ACT_LOAD);
  assign is_start = s_accept && (in_action == ACT_START);
  // A row item only does work while rows of the column remain.
  assign row_go   = s_accept && (in_action == ACT_ROW) && (row_q < limit_q);
  // The pixel moves on once the output register is free or being emptied.
  assign out_load = (state_q == ST_READ) && (!out_valid_q || m_axis_tready);

  // Column setup. A vertical hit uses the east or west face, a horizontal hit
  // the north or south face; west and south read the texture mirrored.
  always_comb begin
    if (!in_side) begin
      start_face = in_xneg ? FACE_WEST : FACE_EAST;
    end else begin
      start_face = in_ypos ? FACE_SOUTH : FACE_NORTH;
    end
    start_mirror = in_side ? in_ypos : in_xneg;
    start_tcol   = in_frac[15 -: TEX_W];
    if (start_mirror) begin
      start_tcol = ~start_tcol;
    end
    height_nz  = (in_height == '0) ? HEIGHT_W'(1) : in_height;
    // Offset of the first row from the slice top; wraps as a 32-bit pattern.
    start_base = 32'(in_first) - 32'(screen_h_q >> 1) + 32'(height_nz >> 1);
  end

  // Texel address: row from the integer part of the position, then column.
  assign tex_row = acc_q[16 +: TEX_W];
  assign tex_xy  = {tex_row, tcol_q};

  assign start_pos = base_q * step_q;

  // North and east faces are drawn darker by halving every channel.
  always_comb begin
    if ((face_q == FACE_NORTH) || (face_q == FACE_EAST)) begin
      shaded = (texel >> 1) & HALF_MASK;
    end else begin
      shaded = texel;
    end
  end

  always_comb begin
    mem_req.wr_en = is_load;
    mem_req.rd_en = row_go;
    mem_req.wdata = in_color;
    if (is_load) begin
      mem_req.addr = {in_face, in_addr};
    end else begin
      mem_req.addr = {face_q, FACE_ADDR_W'(tex_xy)};
    end
  end

  tws_texel_ram u_texel_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (texel)
  );

  tws_step_div #(
    .TEX_SIZE (TEX_SIZE)
  ) u_step_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (is_start),
    .divisor_i (height_nz),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // Sequencer and column state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      screen_h_q  <= SCREEN_H_RST;
      face_q      <= '0;
      tcol_q      <= '0;
      acc_q       <= '0;
      step_q      <= '0;
      row_q       <= '0;
      limit_q     <= '0;
      col_latch_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        screen_h_q <= cfg_data_i;
      end

      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_accept) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (is_start) begin
            face_q      <= start_face;
            tcol_q      <= start_tcol;
            row_q       <= END_W'(in_first);
            limit_q     <= in_end;
            col_latch_q <= in_column;
            state_q     <= ST_DIV;
          end else if (row_go) begin
            acc_q   <= acc_q + step_q;
            row_q   <= row_q + END_W'(1);
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            step_q  <= div_quot;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          acc_q   <= start_pos;
          state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (is_start) begin
      base_q <= start_base;
    end
    if (row_go) begin
      pend_row_q  <= row_q[ROW_W-1:0];
      pend_last_q <= ({1'b0, row_q} + (END_W+1)'(1)) >= {1'b0, limit_q};
    end
    if (out_load) begin
      out_row_q   <= pend_row_q;
      out_col_q   <= col_latch_q;
      out_color_q <= shaded;
      out_we_q    <= (shaded != '0);
      out_last_q  <= pend_last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_color_q, out_col_q, out_row_q};
  assign m_axis_tuser  = out_we_q;
  assign m_axis_tlast  = out_last_q;

  `TWS_ASSERT_NEXT(a_start_enters_div, is_start, state_q == ST_DIV, "start did not launch the divider")
  `TWS_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV, "divider finished outside setup")
  `TWS_ASSERT_IMP(a_step_nonzero, state_q == ST_MUL, step_q != '0, "vertical step is zero")
  `TWS_ASSERT_NEXT(a_pixel_waits, (state_q == ST_READ) && out_valid_q && !m_axis_tready, state_q == ST_READ, "pending pixel dropped while output stalled")

endmodule

`default_nettype wire
